>>> hw/rtl/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Types and constants shared by the RGB to HSV/HLS converter.
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

    localparam int CH_W       = 8;
    localparam int HUE_W      = 15;
    localparam int SAT_W      = 13;
    localparam int LEVEL_W    = 9;
    localparam int QUO_W      = 16;
    localparam int DEN_W      = 8;
    localparam int DIV_STAGES = 4;
    localparam int DIV_STEPS  = QUO_W / DIV_STAGES;
    localparam int PREP_STAGES = 2;
    localparam int STAGES     = PREP_STAGES + DIV_STAGES;

    localparam int SECT_W     = 11;
    localparam int HNUM_W     = 23;
    localparam int SNUM_W     = DEN_W + 12;

    localparam logic MODE_HSV = 1'b0;
    localparam logic MODE_HLS = 1'b1;

    localparam logic [2:0] SECT_RED   = 3'd0;
    localparam logic [2:0] SECT_GREEN = 3'd2;
    localparam logic [2:0] SECT_BLUE  = 3'd4;
    localparam logic [2:0] SECT_WRAP  = 3'd6;

    localparam logic REG_OUTPUT_MODE = 1'b0;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [SAT_W-1:0]   saturation;
        logic [LEVEL_W-1:0] level_doubled;
    } result_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] nq;
        logic [DEN_W-1:0] den;
    } lane_t;

    typedef struct packed {
        logic               grey;
        logic [LEVEL_W-1:0] level;
    } side_t;

    typedef struct packed {
        logic load_s1;
        logic load_s2;
    } prep_ctrl_t;

endpackage

>>> hw/rtl/rgb_to_hsv_hls.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_hls
// RGB pixel to hue, saturation and doubled level, HSV or HLS by register.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the pixel channel (pixel_valid / pixel_ready, payload
//   pixel) and results leave on the result channel (result_valid /
//   result_ready, payload result). One result per pixel, in order.
//   Six register stages: two front stages (extrema and sector, then
//   numerators) and four divider stages of four quotient bits each, hue and
//   saturation side by side. result_valid is the valid flag of the last
//   stage. Throughput is one pixel per cycle while result_ready is high;
//   every stage register is a slot, so a new pixel is taken whenever any
//   slot down the line is free. When result_ready is low the last stage
//   holds its beat and the stages behind it fill up; pixel_ready drops
//   only once all six are full.
//   Reset empties the pipeline and sets output_mode to HSV. output_mode
//   sits at APB address 0, bit 0; write it only while the pipeline is
//   empty. Grey pixels give hue and saturation of zero.
// ----------------------------------------------------------------------------
module rgb_to_hsv_hls
    import rgbhsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  pixel_t      pixel,
    output logic        result_valid,
    input  logic        result_ready,
    output result_t     result
);

    logic                mode_reg;
    logic [STAGES-1:0]   valid_reg;
    logic [STAGES-1:0]   valid_next;
    logic [STAGES-1:0]   adv;
    prep_ctrl_t          prep_ctrl;
    lane_t               hue_lane [DIV_STAGES+1];
    lane_t               sat_lane [DIV_STAGES+1];
    side_t               side_reg [DIV_STAGES+1];
    side_t               side_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_OUTPUT_MODE) ? {31'd0, mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HSV;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_OUTPUT_MODE)
        begin
            mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        adv[STAGES-1] = !valid_reg[STAGES-1] || result_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !valid_reg[i] || adv[i+1];
        end
        valid_next = valid_reg;
        if (adv[0])
        begin
            valid_next[0] = pixel_valid;
        end
        for (int i = 1; i < STAGES; i++)
        begin
            if (adv[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign pixel_ready = adv[0];
    assign prep_ctrl.load_s1 = adv[0];
    assign prep_ctrl.load_s2 = adv[1];

    rgbhsv_prep u_prep
    (
        .clk      (clk),
        .ctrl     (prep_ctrl),
        .mode     (mode_reg),
        .pixel    (pixel),
        .hue_lane (hue_lane[0]),
        .sat_lane (sat_lane[0]),
        .side     (side_reg[0])
    );

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_div
        rgbhsv_div_stage #(.STEPS(DIV_STEPS)) u_hue
        (
            .clk      (clk),
            .load     (adv[PREP_STAGES+s]),
            .lane_in  (hue_lane[s]),
            .lane_out (hue_lane[s+1])
        );

        rgbhsv_div_stage #(.STEPS(DIV_STEPS)) u_sat
        (
            .clk      (clk),
            .load     (adv[PREP_STAGES+s]),
            .lane_in  (sat_lane[s]),
            .lane_out (sat_lane[s+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv[PREP_STAGES+s])
            begin
                side_reg[s+1] <= side_reg[s];
            end
        end
    end

    assign side_out     = side_reg[DIV_STAGES];
    assign result_valid = valid_reg[STAGES-1];

    always_comb
    begin
        result.level_doubled = side_out.level;
        if (side_out.grey)
        begin
            result.hue        = '0;
            result.saturation = '0;
        end
        else
        begin
            result.hue        = hue_lane[DIV_STAGES].nq[HUE_W-1:0];
            result.saturation = sat_lane[DIV_STAGES].nq[SAT_W-1:0];
        end
    end

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_ready |-> &valid_reg)
        else $error("pixel_ready low with a free slot");

    a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !side_out.grey |-> hue_lane[DIV_STAGES].nq < 16'd23040)
        else $error("hue quotient out of range");

    a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !side_out.grey |-> sat_lane[DIV_STAGES].nq <= 16'd4096)
        else $error("saturation quotient out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[PREP_STAGES] && !adv[PREP_STAGES]
        |=> valid_reg[PREP_STAGES] && $stable(hue_lane[1]) && $stable(sat_lane[1]))
        else $error("divider stage lost its beat while stalled");

endmodule

>>> hw/rtl/rgbhsv_prep.sv
// ----------------------------------------------------------------------------
// rgbhsv_prep
// Two front stages: extrema, sector and divisor select, then numerators.
// ----------------------------------------------------------------------------
module rgbhsv_prep
    import rgbhsv_pkg::*;
(
    input  logic       clk,
    input  prep_ctrl_t ctrl,
    input  logic       mode,
    input  pixel_t     pixel,
    output lane_t      hue_lane,
    output lane_t      sat_lane,
    output side_t      side
);

    logic [CH_W-1:0]    mx_c;
    logic [CH_W-1:0]    mn_c;
    logic [CH_W-1:0]    diff_c;
    logic [2:0]         sect_c;
    logic               neg_c;
    logic [LEVEL_W-1:0] sum_c;
    logic [DEN_W-1:0]   sden_c;
    logic [LEVEL_W-1:0] level_c;

    logic [2:0]         sect_reg;
    logic               neg_reg;
    logic [CH_W-1:0]    diff_reg;
    logic [CH_W-1:0]    delta_reg;
    logic [DEN_W-1:0]   sden_reg;
    side_t              side1_reg;

    logic [SECT_W-1:0]  kd_c;
    logic [SECT_W-1:0]  t_c;
    logic [HNUM_W-1:0]  hnum_c;
    logic [SNUM_W-1:0]  snum_c;

    lane_t              hue_next;
    lane_t              sat_next;
    lane_t              hue_reg;
    lane_t              sat_reg;
    side_t              side2_reg;

    always_comb
    begin
        mx_c = pixel.red;
        mn_c = pixel.red;
        if (pixel.green > mx_c) mx_c = pixel.green;
        if (pixel.blue > mx_c)  mx_c = pixel.blue;
        if (pixel.green < mn_c) mn_c = pixel.green;
        if (pixel.blue < mn_c)  mn_c = pixel.blue;

        priority if (mx_c == pixel.red)
        begin
            if (pixel.green >= pixel.blue)
            begin
                sect_c = SECT_RED;
                neg_c  = 1'b0;
                diff_c = pixel.green - pixel.blue;
            end
            else
            begin
                sect_c = SECT_WRAP;
                neg_c  = 1'b1;
                diff_c = pixel.blue - pixel.green;
            end
        end
        else if (mx_c == pixel.green)
        begin
            sect_c = SECT_GREEN;
            neg_c  = pixel.blue < pixel.red;
            diff_c = neg_c ? pixel.red - pixel.blue : pixel.blue - pixel.red;
        end
        else
        begin
            sect_c = SECT_BLUE;
            neg_c  = pixel.red < pixel.green;
            diff_c = neg_c ? pixel.green - pixel.red : pixel.red - pixel.green;
        end

        sum_c = {1'b0, mx_c} + {1'b0, mn_c};
        unique case (mode)
            MODE_HSV:
            begin
                sden_c  = mx_c;
                level_c = {mx_c, 1'b0};
            end
            MODE_HLS:
            begin
                sden_c  = sum_c[LEVEL_W-1] ? DEN_W'(9'd510 - sum_c) : sum_c[DEN_W-1:0];
                level_c = sum_c;
            end
            default:
            begin
                sden_c  = mx_c;
                level_c = {mx_c, 1'b0};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_s1)
        begin
            sect_reg        <= sect_c;
            neg_reg         <= neg_c;
            diff_reg        <= diff_c;
            delta_reg       <= mx_c - mn_c;
            sden_reg        <= sden_c;
            side1_reg.grey  <= (mx_c == mn_c);
            side1_reg.level <= level_c;
        end
    end

    always_comb
    begin
        kd_c   = SECT_W'(sect_reg) * SECT_W'(delta_reg);
        t_c    = neg_reg ? kd_c - SECT_W'(diff_reg) : kd_c + SECT_W'(diff_reg);
        hnum_c = (HNUM_W'(t_c) << 12) - (HNUM_W'(t_c) << 8);
        snum_c = SNUM_W'(delta_reg) << 12;

        hue_next.rem = DEN_W'(hnum_c[HNUM_W-1:QUO_W]);
        hue_next.nq  = hnum_c[QUO_W-1:0];
        hue_next.den = delta_reg;
        sat_next.rem = DEN_W'(snum_c[SNUM_W-1:QUO_W]);
        sat_next.nq  = snum_c[QUO_W-1:0];
        sat_next.den = sden_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_s2)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            side2_reg <= side1_reg;
        end
    end

    assign hue_lane = hue_reg;
    assign sat_lane = sat_reg;
    assign side     = side2_reg;

endmodule

>>> hw/rtl/rgbhsv_div_stage.sv
// ----------------------------------------------------------------------------
// rgbhsv_div_stage
// One stage of a restoring divider: STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module rgbhsv_div_stage
    import rgbhsv_pkg::*;
#(
    parameter int STEPS = 4
)
(
    input  logic  clk,
    input  logic  load,
    input  lane_t lane_in,
    output lane_t lane_out
);

    lane_t lane_next;
    lane_t lane_reg;

    always_comb
    begin
        logic [DEN_W:0] trial;
        lane_next = lane_in;
        for (int i = 0; i < STEPS; i++)
        begin
            trial = {lane_next.rem, lane_next.nq[QUO_W-1]};
            lane_next.nq = {lane_next.nq[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, lane_next.den})
            begin
                lane_next.rem   = DEN_W'(trial - {1'b0, lane_next.den});
                lane_next.nq[0] = 1'b1;
            end
            else
            begin
                lane_next.rem = trial[DEN_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane_out = lane_reg;

endmodule

>>> verif/tb_rgb_to_hsv_hls.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_hls
// Self-checking bench for the RGB to HSV/HLS converter. Pixels are driven on
// the valid/ready input channel, each accepted beat is converted by a local
// fixed-point model under the current output mode, and every result beat is
// compared field by field, in order, against the oldest pending conversion.
// Directed pixels cover greys, the primaries, ties for maximum, hue wrap and
// the narrow HLS denominators; random pixels then run under three idling
// profiles in both modes, with register writes only while the pipe is empty.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_hls;
    import rgbhsv_pkg::*;

    localparam int          CLK_PERIOD     = 12;
    localparam int          CYCLE_LIMIT    = 400000;
    localparam int          SETTLE_CYCLES  = 10;
    localparam logic [2:0]  ADDR_MODE      = {REG_OUTPUT_MODE, 2'b00};
    localparam logic [2:0]  ADDR_NO_REG    = 3'd4;
    localparam int unsigned HUE_SECTOR_Q6  = 3840;
    localparam int unsigned HUE_CIRCLE_Q6  = 23040;
    localparam int unsigned SAT_ONE_Q12    = 4096;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        pixel_valid;
    logic        pixel_ready;
    pixel_t      pixel;
    logic        result_valid;
    logic        result_ready;
    result_t     result;

    result_t     pending_hsv[$];
    logic        mode_shadow;
    int          source_idle_pct;
    int          sink_idle_pct;
    int          error_count;
    int          cycle_count;
    int          pixels_sent;
    int          results_checked;
    int          hls_pixels;

    rgb_to_hsv_hls u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic result_t convert_pixel(pixel_t px, logic mode);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned mx;
        int unsigned mn;
        int unsigned delta;
        int unsigned num;
        int unsigned hue;
        int unsigned sat;
        int unsigned lvl;
        int unsigned sum;
        int unsigned spread;
        int unsigned den;
        result_t     res;
        r     = px.red;
        g     = px.green;
        b     = px.blue;
        mx    = r;
        mn    = r;
        hue   = 0;
        sat   = 0;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        delta = mx - mn;
        if (delta != 0)
        begin
            if (mx == r)
                num = (g >= b) ? HUE_SECTOR_Q6 * (g - b)
                               : HUE_CIRCLE_Q6 * delta - HUE_SECTOR_Q6 * (b - g);
            else if (mx == g)
                num = (b >= r) ? 2 * HUE_SECTOR_Q6 * delta + HUE_SECTOR_Q6 * (b - r)
                               : 2 * HUE_SECTOR_Q6 * delta - HUE_SECTOR_Q6 * (r - b);
            else
                num = (r >= g) ? 4 * HUE_SECTOR_Q6 * delta + HUE_SECTOR_Q6 * (r - g)
                               : 4 * HUE_SECTOR_Q6 * delta - HUE_SECTOR_Q6 * (g - r);
            hue = num / delta;
        end
        if (mode == MODE_HSV)
        begin
            lvl = 2 * mx;
            if (delta != 0)
                sat = (delta * SAT_ONE_Q12) / mx;
        end
        else
        begin
            sum    = mx + mn;
            spread = (sum >= 255) ? sum - 255 : 255 - sum;
            den    = 255 - spread;
            lvl    = sum;
            if (delta != 0 && den != 0)
                sat = (delta * SAT_ONE_Q12) / den;
        end
        res.hue           = HUE_W'(hue);
        res.saturation    = SAT_W'(sat);
        res.level_doubled = LEVEL_W'(lvl);
        return res;
    endfunction

    task automatic send_pixel(input pixel_t px);
        while ($urandom_range(0, 99) < source_idle_pct)
        begin
            pixel_valid <= 1'b0;
            @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= px;
        do
            @(posedge clk);
        while (!pixel_ready);
        pending_hsv.push_back(convert_pixel(px, mode_shadow));
        pixels_sent++;
        if (mode_shadow == MODE_HLS)
            hls_pixels++;
    endtask

    task automatic drain_pipe();
        pixel_valid <= 1'b0;
        while (pending_hsv.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_MODE)
            mode_shadow = data[0];
    endtask

    task automatic apb_check_mode();
        logic [31:0] data;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_MODE;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (data !== {31'b0, mode_shadow})
        begin
            error_count++;
            $display("%0t output_mode read: expected %0h actual %0h",
                     $time, {31'b0, mode_shadow}, data);
        end
    endtask

    function automatic pixel_t make_pixel(int r, int g, int b);
        pixel_t px;
        px.red   = CH_W'(r);
        px.green = CH_W'(g);
        px.blue  = CH_W'(b);
        return px;
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        int     base;
        int     kind;
        kind = $urandom_range(0, 9);
        px   = pixel_t'($urandom());
        if (kind < 3)
        begin
            // near-grey: small spread round a random base
            base     = $urandom_range(0, 255);
            px.red   = CH_W'((base + $urandom_range(0, 3)) % 256);
            px.green = CH_W'((base + $urandom_range(0, 3)) % 256);
            px.blue  = CH_W'((base + $urandom_range(0, 3)) % 256);
        end
        else if (kind < 5)
        begin
            // extremes and ties
            px.red   = ($urandom_range(0, 1) != 0) ? 8'hFF : px.red;
            px.green = ($urandom_range(0, 2) == 0) ? px.red : px.green;
            px.blue  = ($urandom_range(0, 2) == 0) ? 8'h00 : px.blue;
        end
        return px;
    endfunction

    task automatic run_directed();
        pixel_t cases[$];
        cases = '{make_pixel(0, 0, 0),       make_pixel(255, 255, 255),
                  make_pixel(128, 128, 128), make_pixel(255, 0, 0),
                  make_pixel(0, 255, 0),     make_pixel(0, 0, 255),
                  make_pixel(255, 255, 0),   make_pixel(0, 255, 255),
                  make_pixel(255, 0, 255),   make_pixel(255, 0, 1),
                  make_pixel(255, 1, 0),     make_pixel(1, 255, 0),
                  make_pixel(0, 255, 1),     make_pixel(1, 0, 255),
                  make_pixel(0, 1, 255),     make_pixel(1, 0, 0),
                  make_pixel(0, 0, 1),       make_pixel(255, 254, 254),
                  make_pixel(127, 128, 128), make_pixel(254, 255, 255),
                  make_pixel(170, 85, 0)};
        foreach (cases[i])
            send_pixel(cases[i]);
        drain_pipe();
    endtask

    task automatic test_directed_hsv();
        apb_check_mode();
        run_directed();
    endtask

    task automatic test_directed_hls();
        apb_write(ADDR_MODE, {31'b0, MODE_HLS});
        apb_check_mode();
        run_directed();
    endtask

    task automatic test_register_decode();
        apb_write(ADDR_NO_REG, {31'b0, MODE_HSV});
        apb_check_mode();
        apb_write(ADDR_MODE, 32'hFFFF_FFFE);
        apb_check_mode();
        send_pixel(make_pixel(200, 40, 90));
        drain_pipe();
        apb_write(ADDR_MODE, 32'hFFFF_FFFF);
        apb_check_mode();
        send_pixel(make_pixel(200, 40, 90));
        drain_pipe();
    endtask

    task automatic test_random_phase(input int count, input int src_pct, input int sink_pct);
        source_idle_pct = src_pct;
        sink_idle_pct   = sink_pct;
        apb_write(ADDR_MODE, {31'b0, MODE_HSV});
        for (int i = 0; i < count / 2; i++)
        begin
            send_pixel(random_pixel());
            // hold off until the pipe runs dry once, midway through the HSV half
            if (i == count / 4)
                drain_pipe();
        end
        drain_pipe();
        apb_write(ADDR_MODE, {31'b0, MODE_HLS});
        for (int i = 0; i < count - count / 2; i++)
            send_pixel(random_pixel());
        drain_pipe();
    endtask

    initial
    begin
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pixel_valid     = 1'b0;
        pixel           = '0;
        mode_shadow     = MODE_HSV;
        source_idle_pct = 0;
        sink_idle_pct   = 0;
        error_count     = 0;
        pixels_sent     = 0;
        results_checked = 0;
        hls_pixels      = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_hsv();
        test_directed_hls();
        test_register_decode();
        test_random_phase(566, 27, 74);
        test_random_phase(566, 74, 27);
        test_random_phase(568, 0, 0);

        drain_pipe();
        $display("Converted %0d pixels (%0d in HLS mode), %0d result beats checked,",
                 pixels_sent, hls_pixels, results_checked);
        $display("  across greys, hue wrap, maximum ties and three idling profiles.");
        if (error_count == 0)
            $display("rgb_to_hsv_hls test passed");
        else
            $display("rgb_to_hsv_hls test failed");
        $finish;
    end

    initial
    begin
        result_t want;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && result_ready)
            begin
                results_checked++;
                if (pending_hsv.size() == 0)
                begin
                    error_count++;
                    $display("%0t unexpected result beat: expected none actual %h",
                             $time, result);
                end
                else
                begin
                    want = pending_hsv.pop_front();
                    if (result.hue !== want.hue)
                    begin
                        error_count++;
                        $display("%0t hue: expected %0d actual %0d",
                                 $time, want.hue, result.hue);
                    end
                    if (result.saturation !== want.saturation)
                    begin
                        error_count++;
                        $display("%0t saturation: expected %0d actual %0d",
                                 $time, want.saturation, result.saturation);
                    end
                    if (result.level_doubled !== want.level_doubled)
                    begin
                        error_count++;
                        $display("%0t level_doubled: expected %0d actual %0d",
                                 $time, want.level_doubled, result.level_doubled);
                    end
                end
            end
            result_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("Timed out after %0d cycles with %0d results pending",
                         cycle_count, pending_hsv.size());
                $display("rgb_to_hsv_hls test failed");
                $finish;
            end
        end
    end

endmodule
